### rtl/sqb_pkg.sv
// Shared types, codes and defaults for the shortest queue balancer.
package sqb_pkg;

	localparam int NUM_QUEUES_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int DATA_W          = 32;

	typedef enum logic [1:0] {
		OP_INS_SHORT = 2'd0,
		OP_DEL_LONG  = 2'd1,
		OP_INS_NAMED = 2'd2
	} sqb_op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} sqb_status_t;

	typedef struct packed {
		sqb_op_t                   op;
		logic [1:0]                target_queue;
		logic signed [DATA_W-1:0]  value_in;
	} sqb_req_t;

	typedef struct packed {
		sqb_status_t               status;
		logic [1:0]                queue_used;
		logic signed [DATA_W-1:0]  value_out;
	} sqb_res_t;

	// Decision handed from the scheduler to the datapath.
	typedef struct packed {
		logic        wr;
		logic        rd;
		sqb_status_t status;
		logic [1:0]  queue_used;
	} sqb_cmd_t;

endpackage

### rtl/shortest_queue_balancer.sv
// A request is decided by the scheduler and its store read issued as it is accepted; the
// decision then waits in stage 1 for the read data and moves on into the output register.
// Throughput: one request per cycle; the single store port is used by the accepted request
// only, and a waiting result in the output register stalls requests only once stage 1 also
// holds one. Reset clears every fill count and every head and tail pointer at once; the shared
// store needs no clearing pass, since a delete only reads slots that an insert wrote.
module shortest_queue_balancer #(
	parameter int NUM_QUEUES  = sqb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = sqb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sqb_pkg::sqb_req_t req,
	output logic              res_valid,
	input  logic              res_ready,
	output sqb_pkg::sqb_res_t res
);
	import sqb_pkg::*;

	localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

	logic            go;
	sqb_cmd_t        cmd;
	logic [AW-1:0]   addr;
	logic [DATA_W-1:0] rdata;

	// Stage 1 holds the decision while the store read completes.
	logic            valid_s1;
	sqb_cmd_t        cmd_s1;
	logic            move_s1;

	logic            res_valid_q;
	sqb_res_t        res_q;

	// Stage 1 may advance when the output register is empty or is being emptied. A new
	// request is taken whenever stage 1 is free or advancing in the same cycle.
	assign move_s1   = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || move_s1;
	assign go        = req_valid && req_ready;

	// The scheduler decides the queue and updates pointers and counts as the request
	// is accepted, so the next request already sees the new state.
	sqb_sched #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_sched (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.req   (req),
		.cmd   (cmd),
		.addr  (addr)
	);

	// An insert writes the word in the accept cycle; a delete reads it, and the registered
	// data arrives while the decision sits in stage 1. The read data only changes on a
	// new read, so it holds while stage 1 is stalled.
	sqb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_QUEUES * QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (go && cmd.wr),
		.re   (go && cmd.rd),
		.addr (addr),
		.wdata(req.value_in),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cmd_s1 <= cmd;
		end
	end

	// Output register: the value field carries the removed word only for a delete
	// that found an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q.status     <= cmd_s1.status;
			res_q.queue_used <= cmd_s1.queue_used;
			res_q.value_out  <= cmd_s1.rd ? $signed(rdata) : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !res_ready |-> !req_ready)
		else $error("request taken while both stages are held");
`endif

endmodule

### rtl/sqb_ram.sv
// Generic single-port synchronous RAM with registered read data.
module sqb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/sqb_sched.sv
// Queue scheduler: fill counts, head and tail pointers, and queue choice.
module sqb_sched #(
	parameter int NUM_QUEUES  = sqb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = sqb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      go,
	input  sqb_pkg::sqb_req_t                         req,
	output sqb_pkg::sqb_cmd_t                         cmd,
	output logic [$clog2(NUM_QUEUES*QUEUE_DEPTH)-1:0] addr
);
	import sqb_pkg::*;

	localparam int QW = $clog2(NUM_QUEUES);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

	logic [CW-1:0] count_q [NUM_QUEUES];
	logic [PW-1:0] head_q  [NUM_QUEUES];
	logic [PW-1:0] tail_q  [NUM_QUEUES];

	logic [NUM_QUEUES-1:0] win_min, win_max;
	logic [QW-1:0]         short_idx, long_idx, sel_q, tq_idx;
	logic [QW+1:0]         tq_wide;
	logic                  tq_ok, clear_ptrs;
	logic [PW-1:0]         ptr, ptr_next;
	logic                  count_ovf, ptrs_nz;

	// A queue wins the shortest search when every lower queue is strictly longer and
	// every higher queue is at least as long; the longest search mirrors this. At most
	// one queue can win each, so the winner index is an OR over the winners.
	always_comb begin
		win_min   = '0;
		win_max   = '0;
		short_idx = '0;
		long_idx  = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			win_min[i] = (count_q[i] != CW'(QUEUE_DEPTH));
			win_max[i] = (count_q[i] != '0);
			for (int j = 0; j < NUM_QUEUES; j++) begin
				if (j < i) begin
					win_min[i] = win_min[i] && (count_q[j] > count_q[i]);
					win_max[i] = win_max[i] && (count_q[j] < count_q[i]);
				end else if (j > i) begin
					win_min[i] = win_min[i] && (count_q[j] >= count_q[i]);
					win_max[i] = win_max[i] && (count_q[j] <= count_q[i]);
				end
			end
			if (win_min[i]) begin
				short_idx = short_idx | QW'(i);
			end
			if (win_max[i]) begin
				long_idx = long_idx | QW'(i);
			end
		end
	end

	assign tq_wide = (QW+2)'(req.target_queue);
	assign tq_ok   = tq_wide < (QW+2)'(NUM_QUEUES);
	assign tq_idx  = tq_wide[QW-1:0];

	always_comb begin
		cmd        = '{wr: 1'b0, rd: 1'b0, status: ST_DONE, queue_used: 2'd0};
		sel_q      = '0;
		clear_ptrs = 1'b0;
		unique case (req.op)
			OP_INS_SHORT: begin
				if (|win_min) begin
					cmd.wr = 1'b1;
					sel_q  = short_idx;
				end else begin
					cmd.status = ST_FULL;
				end
			end
			OP_DEL_LONG: begin
				if (|win_max) begin
					cmd.rd = 1'b1;
					sel_q  = long_idx;
				end else begin
					cmd.status = ST_EMPTY;
					clear_ptrs = 1'b1;
				end
			end
			OP_INS_NAMED: begin
				if (tq_ok && (count_q[tq_idx] != CW'(QUEUE_DEPTH))) begin
					cmd.wr = 1'b1;
					sel_q  = tq_idx;
				end else begin
					cmd.status = ST_FULL;
				end
			end
			default: begin
			end
		endcase
		if (cmd.wr || cmd.rd) begin
			cmd.queue_used = 2'(sel_q);
		end
	end

	// Region base plus offset; pointers wrap inside the queue's own region.
	assign ptr      = cmd.wr ? tail_q[sel_q] : head_q[sel_q];
	assign ptr_next = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
	assign addr     = AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(ptr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
		end else if (go) begin
			if (cmd.wr) begin
				tail_q[sel_q]  <= ptr_next;
				count_q[sel_q] <= count_q[sel_q] + CW'(1);
			end
			if (cmd.rd) begin
				head_q[sel_q]  <= ptr_next;
				count_q[sel_q] <= count_q[sel_q] - CW'(1);
			end
			if (clear_ptrs) begin
				for (int i = 0; i < NUM_QUEUES; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
				end
			end
		end
	end

	always_comb begin
		count_ovf = 1'b0;
		ptrs_nz   = 1'b0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			count_ovf = count_ovf || (count_q[i] > CW'(QUEUE_DEPTH));
			ptrs_nz   = ptrs_nz || (head_q[i] != '0) || (tail_q[i] != '0);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!count_ovf)
		else $error("fill count beyond queue depth");
	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr && cmd.rd))
		else $error("write and read chosen together");
	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && clear_ptrs |=> !ptrs_nz)
		else $error("pointers not cleared after empty delete");
`endif

endmodule
